>>> sv/toc_pkg.sv
// Package for the tetrahedron orientation checker.
// Holds the store and arithmetic widths, the item kinds, and the result codes.
// It has no dependencies and is imported by tetra_orientation_checker, tetra_result_checker and the testbench top.
package toc_pkg;

    localparam int MAX_POSITIONS = 4096;
    localparam int COORD_BITS    = 20;

    localparam int ADDR_W  = $clog2(MAX_POSITIONS);
    localparam int POS_W   = 3 * COORD_BITS;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int LO_W    = DIFF_W + 1;
    localparam int HI_W    = CROSS_W - LO_W;
    localparam int MULA_W  = DIFF_W + 2;
    localparam int PROD_W  = MULA_W + DIFF_W;
    localparam int VOL_W   = 3 * DIFF_W + 2;
    localparam int EPS_W   = 48;
    localparam int CMP_W   = (VOL_W > EPS_W) ? VOL_W : EPS_W;

    localparam int COUNT_W = 13;
    localparam int IDX_W   = 14;
    localparam int NUM_W   = 24;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_CHECK    = 2'd1,
        KIND_NEW_MESH = 2'd2
    } t_kind;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_BAD_INDEX    = 2'd1;
    localparam logic [1:0] STATUS_INCONSISTENT = 2'd2;

    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    localparam logic CFG_POSITION_COUNT = 1'b0;
    localparam logic CFG_VOLUME_EPSILON = 1'b1;

endpackage

>>> sv/tetra_orientation_checker.sv
// Top level of the tetrahedron orientation checker: position store, index check,
// one shared multiplier under a sequencer, and the orientation bookkeeping.
// Depends on toc_pkg and toc_ram.
//
//   Channel   Direction  Signals                        Contents
//   s_axis    in         tvalid tready tdata[127:0] tuser[1:0]  mesh items
//   m_axis    out        tvalid tready tdata[47:0]      check results
//   cfg       in         i_cfg_we i_cfg_index i_cfg_data[47:0]  register writes
//
// A position write or a new-mesh item leaves the sequencer idle. A tetrahedron
// that is rejected, or checked against an empty store, goes straight to the done
// state, and its result is loaded into the output register once that register
// is free. A full check reads the four corners through the single store read
// port, forms twelve products on the one multiplier, then takes the magnitude,
// compares it against epsilon and loads the output register. Reset clears the
// position count, reference sign and counter and sets epsilon to 2; the store is
// not cleared. A result waits in the output register while new items are taken;
// a second result then waits in the sequencer until that register is free.
module tetra_orientation_checker
    import toc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // position_index, pos_x, pos_y, pos_z, vertex_a, vertex_b, vertex_c, vertex_d
    input  logic [127:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, orientation, tetra_number, bad_index, six zero bits
    output logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [47:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ABS,
        S_CMP,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        M_X_A, M_X_B, M_Y_A, M_Y_B, M_Z_A, M_Z_B,
        M_D0_LO, M_D0_HI, M_D1_LO, M_D1_HI, M_D2_LO, M_D2_HI
    } t_mstep;

    localparam logic [3:0] MUL_STEPS = 4'd12;

    t_state                    r_state;
    logic [COUNT_W-1:0]        r_pos_count;
    logic [EPS_W-1:0]          r_eps;
    logic [1:0]                r_ref;
    logic [NUM_W-1:0]          r_counter;

    logic [ADDR_W-1:0]         r_vaddr [4];
    logic [2:0]                r_rcnt;
    logic signed [COORD_BITS-1:0] r_p  [3];
    logic signed [DIFF_W-1:0]  r_dq [3];
    logic signed [DIFF_W-1:0]  r_dr [3];
    logic signed [DIFF_W-1:0]  r_ds [3];

    logic [3:0]                r_mcnt;
    logic signed [PROD_W-1:0]  r_prod;
    t_mstep                    r_pstep;
    logic                      r_pvld;
    logic signed [CROSS_W-1:0] r_cross [3];
    logic signed [VOL_W-1:0]   r_vol;
    logic [VOL_W-1:0]          r_abs;
    logic                      r_neg;

    logic [1:0]                r_res_status;
    logic [1:0]                r_res_orient;
    logic [NUM_W-1:0]          r_res_number;
    logic [IDX_W-1:0]          r_res_bad;

    logic                      r_m_valid;
    logic [1:0]                r_m_status;
    logic [1:0]                r_m_orient;
    logic [NUM_W-1:0]          r_m_number;
    logic [IDX_W-1:0]          r_m_bad;

    logic                      w_accept;
    logic [11:0]               w_pos_index;
    logic [19:0]               w_pos_x;
    logic [19:0]               w_pos_y;
    logic [19:0]               w_pos_z;
    logic [IDX_W-1:0]          w_vtx [4];
    logic [3:0]                w_idx_ok;
    logic                      w_bad_found;
    logic [IDX_W-1:0]          w_bad_idx;

    logic                      w_ram_we;
    logic [ADDR_W-1:0]         w_ram_waddr;
    logic [POS_W-1:0]          w_ram_wdata;
    logic [ADDR_W-1:0]         w_ram_raddr;
    logic [POS_W-1:0]          w_ram_rdata;
    logic signed [COORD_BITS-1:0] w_rd [3];
    logic signed [DIFF_W-1:0]  w_diff [3];

    logic signed [HI_W-1:0]    w_hi [3];
    logic signed [MULA_W-1:0]  w_mul_a;
    logic signed [DIFF_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [CROSS_W-1:0] w_prod_cross;
    logic signed [VOL_W-1:0]   w_prod_vol;
    logic signed [VOL_W-1:0]   w_prod_vol_hi;

    logic                      w_small;
    logic [1:0]                w_sign;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_pos_index = s_axis_tdata[11:0];
    assign w_pos_x     = s_axis_tdata[31:12];
    assign w_pos_y     = s_axis_tdata[51:32];
    assign w_pos_z     = s_axis_tdata[71:52];
    assign w_vtx[0]    = s_axis_tdata[85:72];
    assign w_vtx[1]    = s_axis_tdata[99:86];
    assign w_vtx[2]    = s_axis_tdata[113:100];
    assign w_vtx[3]    = s_axis_tdata[127:114];

    // Corner indices are tested in order; the first failing one is reported.
    always_comb begin
        w_bad_found = 1'b0;
        w_bad_idx   = '0;
        for (int k = 0; k < 4; k++) begin
            w_idx_ok[k] = !w_vtx[k][IDX_W-1] && (w_vtx[k][COUNT_W-1:0] < r_pos_count)
                          && (32'(w_vtx[k][COUNT_W-1:0]) < MAX_POSITIONS);
            if (!w_bad_found && !w_idx_ok[k]) begin
                w_bad_found = 1'b1;
                w_bad_idx   = w_vtx[k];
            end
        end
    end

    assign w_ram_we    = w_accept && (s_axis_tuser == KIND_WRITE)
                         && (32'(w_pos_index) < MAX_POSITIONS);
    assign w_ram_waddr = ADDR_W'(w_pos_index);
    assign w_ram_wdata = {COORD_BITS'(w_pos_z), COORD_BITS'(w_pos_y), COORD_BITS'(w_pos_x)};
    assign w_ram_raddr = r_vaddr[r_rcnt[1:0]];

    toc_ram #(
        .WIDTH (POS_W),
        .DEPTH (MAX_POSITIONS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rd[k]   = signed'(w_ram_rdata[k*COORD_BITS +: COORD_BITS]);
            w_diff[k] = DIFF_W'(w_rd[k]) - DIFF_W'(r_p[k]);
            w_hi[k]   = signed'(r_cross[k][CROSS_W-1:LO_W]);
        end
    end

    // Operand selection for the shared multiplier. The dot product splits each
    // cross component into an unsigned low part and a signed high part.
    always_comb begin
        unique case (t_mstep'(r_mcnt))
            M_X_A: begin
                w_mul_a = MULA_W'(r_dr[1]);
                w_mul_b = r_dq[2];
            end
            M_X_B: begin
                w_mul_a = MULA_W'(r_dq[1]);
                w_mul_b = r_dr[2];
            end
            M_Y_A: begin
                w_mul_a = MULA_W'(r_dr[2]);
                w_mul_b = r_dq[0];
            end
            M_Y_B: begin
                w_mul_a = MULA_W'(r_dq[2]);
                w_mul_b = r_dr[0];
            end
            M_Z_A: begin
                w_mul_a = MULA_W'(r_dr[0]);
                w_mul_b = r_dq[1];
            end
            M_Z_B: begin
                w_mul_a = MULA_W'(r_dq[0]);
                w_mul_b = r_dr[1];
            end
            M_D0_LO: begin
                w_mul_a = signed'({1'b0, r_cross[0][LO_W-1:0]});
                w_mul_b = r_ds[0];
            end
            M_D0_HI: begin
                w_mul_a = MULA_W'(w_hi[0]);
                w_mul_b = r_ds[0];
            end
            M_D1_LO: begin
                w_mul_a = signed'({1'b0, r_cross[1][LO_W-1:0]});
                w_mul_b = r_ds[1];
            end
            M_D1_HI: begin
                w_mul_a = MULA_W'(w_hi[1]);
                w_mul_b = r_ds[1];
            end
            M_D2_LO: begin
                w_mul_a = signed'({1'b0, r_cross[2][LO_W-1:0]});
                w_mul_b = r_ds[2];
            end
            M_D2_HI: begin
                w_mul_a = MULA_W'(w_hi[2]);
                w_mul_b = r_ds[2];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod        = w_mul_a * w_mul_b;
    assign w_prod_cross  = CROSS_W'(r_prod);
    assign w_prod_vol    = VOL_W'(r_prod);
    assign w_prod_vol_hi = w_prod_vol <<< LO_W;

    assign w_small = (r_abs == '0) || (CMP_W'(r_abs) < CMP_W'(r_eps));
    assign w_sign  = w_small ? SIGN_ZERO : (r_neg ? SIGN_NEG : SIGN_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos_count <= '0;
            r_eps       <= EPS_W'(2);
            r_ref       <= SIGN_ZERO;
            r_counter   <= '0;
            r_m_valid   <= 1'b0;
            r_rcnt      <= '0;
            r_mcnt      <= '0;
            r_pvld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POSITION_COUNT: r_pos_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_VOLUME_EPSILON: r_eps       <= i_cfg_data[EPS_W-1:0];
                endcase
            end

            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (s_axis_tuser)
                            KIND_CHECK: begin
                                r_res_number <= r_counter;
                                if (r_counter != NUM_MAX) begin
                                    r_counter <= r_counter + 1'b1;
                                end
                                r_res_orient <= SIGN_ZERO;
                                for (int k = 0; k < 4; k++) begin
                                    r_vaddr[k] <= ADDR_W'(w_vtx[k][COUNT_W-1:0]);
                                end
                                if (r_pos_count == '0) begin
                                    r_res_status <= STATUS_OK;
                                    r_res_bad    <= '0;
                                    r_state      <= S_DONE;
                                end else if (w_bad_found) begin
                                    r_res_status <= STATUS_BAD_INDEX;
                                    r_res_bad    <= w_bad_idx;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= STATUS_OK;
                                    r_res_bad    <= '0;
                                    r_rcnt       <= '0;
                                    r_state      <= S_READ;
                                end
                            end
                            KIND_NEW_MESH: begin
                                r_ref     <= SIGN_ZERO;
                                r_counter <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_rcnt <= r_rcnt + 1'b1;
                    unique case (r_rcnt)
                        3'd1: r_p  <= w_rd;
                        3'd2: r_dq <= w_diff;
                        3'd3: r_dr <= w_diff;
                        3'd4: begin
                            r_ds    <= w_diff;
                            r_mcnt  <= '0;
                            r_pvld  <= 1'b0;
                            r_state <= S_MUL;
                        end
                        default: begin
                        end
                    endcase
                end
                S_MUL: begin
                    r_mcnt  <= r_mcnt + 1'b1;
                    r_prod  <= w_prod;
                    r_pstep <= t_mstep'(r_mcnt);
                    r_pvld  <= (r_mcnt < MUL_STEPS);
                    if (r_pvld) begin
                        unique case (r_pstep)
                            M_X_A:   r_cross[0] <= w_prod_cross;
                            M_X_B:   r_cross[0] <= r_cross[0] - w_prod_cross;
                            M_Y_A:   r_cross[1] <= w_prod_cross;
                            M_Y_B:   r_cross[1] <= r_cross[1] - w_prod_cross;
                            M_Z_A:   r_cross[2] <= w_prod_cross;
                            M_Z_B:   r_cross[2] <= r_cross[2] - w_prod_cross;
                            M_D0_LO: r_vol <= w_prod_vol;
                            M_D0_HI,
                            M_D1_HI,
                            M_D2_HI: r_vol <= r_vol + w_prod_vol_hi;
                            M_D1_LO,
                            M_D2_LO: r_vol <= r_vol + w_prod_vol;
                            default: begin
                            end
                        endcase
                    end
                    if (r_mcnt == MUL_STEPS) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_vol[VOL_W-1];
                    r_abs   <= r_vol[VOL_W-1] ? VOL_W'(-r_vol) : VOL_W'(r_vol);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_res_orient <= w_sign;
                    if (w_sign != SIGN_ZERO) begin
                        if (r_ref == SIGN_ZERO) begin
                            r_ref <= w_sign;
                        end else if (w_sign != r_ref) begin
                            r_res_status <= STATUS_INCONSISTENT;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= r_res_status;
                        r_m_orient <= r_res_orient;
                        r_m_number <= r_res_number;
                        r_m_bad    <= r_res_bad;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_bad, r_m_number, r_m_orient, r_m_status};

    // The reference sign only changes from nonzero by returning to zero.
    a_ref_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ref != SIGN_ZERO && $past(r_ref) != SIGN_ZERO) |-> r_ref == $past(r_ref))
        else $error("reference sign flipped without a new mesh");

    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_CHECK)
        |=> r_state != S_IDLE)
        else $error("check transaction did not start the sequencer");

    a_bad_no_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status == STATUS_BAD_INDEX) |-> r_m_orient == SIGN_ZERO)
        else $error("rejected tetrahedron carries an orientation");

    a_incons_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_status == STATUS_INCONSISTENT) |-> r_m_orient != SIGN_ZERO)
        else $error("inconsistent result without a sign");

endmodule

>>> sv/toc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used as the vertex position store; no dependencies.
module toc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> test/tetra_result_checker.sv
// Result checker for the tetrahedron orientation checker testbench.
// Watches the item, result and register channels, predicts each result and compares it.
// Depends on toc_pkg for widths, item kinds, status and sign codes.
module tetra_result_checker
    import toc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // position_index, pos_x, pos_y, pos_z, vertex_a, vertex_b, vertex_c, vertex_d
    input  logic [127:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, orientation, tetra_number, bad_index, six zero bits
    input  logic [47:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [47:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);

    // The last declared member sits in the lowest bits, so x matches tdata[31:12].
    typedef struct packed {
        logic signed [COORD_BITS-1:0] z;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_point;

    typedef struct packed {
        logic [1:0]       status;
        logic [1:0]       orientation;
        logic [NUM_W-1:0] number;
        logic [IDX_W-1:0] bad_index;
    } t_tetra_result;

    t_point           vertex_mem [MAX_POSITIONS];
    t_tetra_result    expected_results [$];
    logic [1:0]       first_sign;
    logic [NUM_W-1:0] tetra_seq;
    logic [COUNT_W-1:0] valid_count;
    logic [EPS_W-1:0] eps_limit;

    function automatic logic [1:0] volume_class(input t_point p, input t_point q,
                                                input t_point r, input t_point s);
        logic signed [127:0] qx, qy, qz, rx, ry, rz, sx, sy, sz, cx, cy, cz, vol;
        logic [127:0]        mag;
        qx = $signed(q.x) - $signed(p.x);
        qy = $signed(q.y) - $signed(p.y);
        qz = $signed(q.z) - $signed(p.z);
        rx = $signed(r.x) - $signed(p.x);
        ry = $signed(r.y) - $signed(p.y);
        rz = $signed(r.z) - $signed(p.z);
        sx = $signed(s.x) - $signed(p.x);
        sy = $signed(s.y) - $signed(p.y);
        sz = $signed(s.z) - $signed(p.z);
        cx = ry * qz - qy * rz;
        cy = rz * qx - qz * rx;
        cz = rx * qy - qx * ry;
        vol = cx * sx + cy * sy + cz * sz;
        mag = (vol < 0) ? -vol : vol;
        if (mag == 0 || mag < eps_limit) begin
            return SIGN_ZERO;
        end
        return (vol < 0) ? SIGN_NEG : SIGN_POS;
    endfunction

    task automatic predict_tetra_result(input logic [1:0] kind, input logic [127:0] data);
        logic [IDX_W-1:0] corner [4];
        t_tetra_result    res;
        int               limit;
        int               k;
        corner[0] = data[85:72];
        corner[1] = data[99:86];
        corner[2] = data[113:100];
        corner[3] = data[127:114];
        case (kind)
            KIND_WRITE: begin
                vertex_mem[data[ADDR_W-1:0]] = data[71:12];
            end
            KIND_NEW_MESH: begin
                first_sign = SIGN_ZERO;
                tetra_seq  = '0;
            end
            KIND_CHECK: begin
                res = '0;
                res.number = tetra_seq;
                if (tetra_seq != NUM_MAX) begin
                    tetra_seq = tetra_seq + 1'b1;
                end
                limit = (valid_count > MAX_POSITIONS) ? MAX_POSITIONS : valid_count;
                if (limit != 0) begin
                    for (k = 0; k < 4; k++) begin
                        if (res.status == STATUS_OK &&
                            (corner[k][IDX_W-1] || corner[k] >= limit)) begin
                            res.status    = STATUS_BAD_INDEX;
                            res.bad_index = corner[k];
                        end
                    end
                    if (res.status == STATUS_OK) begin
                        res.orientation = volume_class(vertex_mem[corner[0][ADDR_W-1:0]],
                                                       vertex_mem[corner[1][ADDR_W-1:0]],
                                                       vertex_mem[corner[2][ADDR_W-1:0]],
                                                       vertex_mem[corner[3][ADDR_W-1:0]]);
                        if (res.orientation != SIGN_ZERO) begin
                            if (first_sign == SIGN_ZERO) begin
                                first_sign = res.orientation;
                            end else if (res.orientation != first_sign) begin
                                res.status = STATUS_INCONSISTENT;
                            end
                        end
                    end
                end
                expected_results.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    task automatic compare_field(input string name, input logic [NUM_W-1:0] want,
                                 input logic [NUM_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_result(input logic [47:0] word);
        t_tetra_result want;
        if (expected_results.size() == 0) begin
            $error("result transaction %h arrived with nothing expected", word);
            o_fail_count++;
        end else begin
            want = expected_results.pop_front();
            compare_field("status", NUM_W'(want.status), NUM_W'(word[1:0]));
            compare_field("orientation", NUM_W'(want.orientation), NUM_W'(word[3:2]));
            compare_field("tetra_number", want.number, word[27:4]);
            compare_field("bad_index", NUM_W'(want.bad_index), NUM_W'(word[41:28]));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            first_sign   = SIGN_ZERO;
            tetra_seq    = '0;
            valid_count  = '0;
            eps_limit    = 48'd2;
            expected_results.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                compare_result(m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_tetra_result(s_axis_tuser, s_axis_tdata);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_POSITION_COUNT) begin
                    valid_count = i_cfg_data[COUNT_W-1:0];
                end else begin
                    eps_limit = i_cfg_data[EPS_W-1:0];
                end
            end
            o_pending = expected_results.size();
        end
    end

endmodule

>>> test/tetra_orientation_checker_tb.sv
// Testbench top for the tetrahedron orientation checker: clock, reset, mesh stimulus and verdict.
// Builds meshes, checks tetrahedra under several register settings, and idles both channels.
// Depends on toc_pkg, tetra_orientation_checker and tetra_result_checker.
module tetra_orientation_checker_tb;
    import toc_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 1000000;
    localparam int         ITEM_TARGET = 2000;
    localparam int         DRAIN_CYCLES = 30;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic         i_cfg_index;
    logic [47:0]  i_cfg_data;

    int   fail_count;
    int   pending_results;
    int   items_sent = 0;
    int   reg_count = 0;
    int   mesh_slots [$];
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    bit   hold_go = 1'b0;
    logic rx_hold;

    tetra_orientation_checker u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tetra_result_checker u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: a random stall after every transaction unless rx_calm is set, and one long hold on request.
    initial begin
        int stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                stall = rx_calm ? 0 : $urandom_range(0, 10);
            end else if (stall > 0) begin
                stall--;
            end
            m_axis_tready <= (stall == 0) && !rx_hold;
        end
    end

    initial begin
        rx_hold <= 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    function automatic logic [COORD_BITS-1:0] rand_coord(input int bits);
        logic signed [31:0] v;
        v = $urandom;
        v = v >>> (32 - bits);
        return v[COORD_BITS-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] rand_index();
        return IDX_W'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] stray_index(input int cnt);
        if ($urandom_range(0, 1) == 1) begin
            return IDX_W'($urandom_range(8192, 16383));
        end
        return IDX_W'($urandom_range(cnt, 8191));
    endfunction

    function automatic logic [IDX_W-1:0] pick_slot();
        return IDX_W'(mesh_slots[$urandom_range(0, mesh_slots.size() - 1)]);
    endfunction

    task automatic send(input logic [1:0] kind, input logic [127:0] data);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind != KIND_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic put_vertex(input int slot, input logic [COORD_BITS-1:0] x,
                              input logic [COORD_BITS-1:0] y,
                              input logic [COORD_BITS-1:0] z);
        send(KIND_WRITE, {rand_index(), rand_index(), rand_index(), rand_index(),
                          z, y, x, ADDR_W'(slot)});
    endtask

    task automatic check_tetra(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                               input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] d);
        send(KIND_CHECK, {d, c, b, a, POS_W'({$urandom, $urandom}), ADDR_W'($urandom)});
    endtask

    // Stops offering items, waits for every result, then lets in-flight work finish.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(input int cnt, input logic [EPS_W-1:0] eps);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_POSITION_COUNT;
        i_cfg_data  <= 48'(cnt);
        @(posedge i_clk);
        i_cfg_index <= CFG_VOLUME_EPSILON;
        i_cfg_data  <= eps;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_count = cnt;
    endtask

    task automatic random_phase();
        logic [IDX_W-1:0] tet [4];
        logic [IDX_W-1:0] prev [4];
        logic [63:0]      wide_rand;
        logic [EPS_W-1:0] eps;
        int               cnt, bits, n_vert, n_tetra, base, sel, k, t;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       cnt = 0;
            1:       cnt = MAX_POSITIONS;
            2:       cnt = $urandom_range(1, 4);
            3, 4, 5: cnt = $urandom_range(5, MAX_POSITIONS);
            default: cnt = $urandom_range(16, 128);
        endcase
        sel = $urandom_range(0, 5);
        wide_rand = {$urandom, $urandom};
        case (sel)
            0:       eps = '0;
            1:       eps = '1;
            2:       eps = 48'd2;
            default: eps = EPS_W'(wide_rand >> (64 - $urandom_range(0, 48)));
        endcase
        bits = ($urandom_range(0, 2) == 0) ? COORD_BITS : $urandom_range(2, COORD_BITS - 1);
        set_regs(cnt, eps);
        tx_calm = ($urandom_range(0, 4) == 0);
        rx_calm = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 1) == 1) begin
            send(KIND_NEW_MESH, {$urandom, $urandom, $urandom, $urandom});
        end
        n_vert = $urandom_range(4, 12);
        if (cnt != 0 && n_vert > cnt) begin
            n_vert = cnt;
        end
        base = $urandom_range(0, ((cnt != 0) ? cnt : MAX_POSITIONS) - n_vert);
        mesh_slots.delete();
        for (k = 0; k < n_vert; k++) begin
            put_vertex(base + k, rand_coord(bits), rand_coord(bits), rand_coord(bits));
            mesh_slots.push_back(base + k);
        end
        for (k = 0; k < 4; k++) begin
            prev[k] = (cnt != 0) ? pick_slot() : rand_index();
        end
        n_tetra = $urandom_range(10, 40);
        for (t = 0; t < n_tetra; t++) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                send(KIND_UNUSED, {$urandom, $urandom, $urandom, $urandom});
            end else if (sel == 1) begin
                put_vertex(pick_slot(), rand_coord(bits), rand_coord(bits), rand_coord(bits));
            end else if (sel == 2) begin
                send(KIND_NEW_MESH, {$urandom, $urandom, $urandom, $urandom});
            end else begin
                tet = prev;
                if (cnt == 0) begin
                    for (k = 0; k < 4; k++) tet[k] = rand_index();
                end else if (sel <= 4) begin
                    for (k = 0; k < 4; k++) tet[k] = pick_slot();
                    tet[$urandom_range(0, 3)] = stray_index(cnt);
                    if ($urandom_range(0, 1) == 1) begin
                        tet[$urandom_range(0, 3)] = stray_index(cnt);
                    end
                end else if (sel <= 6) begin
                    tet[0] = prev[1];
                    tet[1] = prev[0];
                end else if (sel <= 8) begin
                    tet[0] = prev[1];
                    tet[1] = prev[2];
                    tet[2] = prev[0];
                end else if (sel == 9) begin
                    tet[3] = prev[$urandom_range(0, 2)];
                end else begin
                    for (k = 0; k < 4; k++) tet[k] = pick_slot();
                end
                check_tetra(tet[0], tet[1], tet[2], tet[3]);
                prev = tet;
            end
        end
    endtask

    initial begin
        int k;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_WRITE;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_POSITION_COUNT;
        i_cfg_data    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With no valid positions every tetrahedron passes, whatever its indices.
        check_tetra(0, 1, 2, 3);
        check_tetra(-8192, 8191, -1, 4096);
        send(KIND_UNUSED, {$urandom, $urandom, $urandom, $urandom});
        put_vertex(0, 0, 0, 0);
        put_vertex(1, 256, 0, 0);
        put_vertex(2, 0, 256, 0);
        put_vertex(3, 0, 0, 256);
        put_vertex(4, -524288, -524288, -524288);
        put_vertex(5, 524287, -524288, -524288);
        put_vertex(6, -524288, 524287, -524288);
        put_vertex(7, -524288, -524288, 524287);
        put_vertex(4095, 524287, 524287, 524287);

        set_regs(MAX_POSITIONS, '0);
        check_tetra(0, 1, 2, 3);
        check_tetra(0, 2, 1, 3);
        check_tetra(0, 0, 1, 2);
        check_tetra(-8192, 1, 2, 3);
        check_tetra(0, 4096, -1, 2);
        check_tetra(0, 1, 2, 8191);
        check_tetra(4, 5, 6, 7);
        check_tetra(4095, 5, 6, 7);
        send(KIND_NEW_MESH, '0);
        check_tetra(0, 2, 1, 3);

        set_regs(4, '1);
        check_tetra(0, 1, 2, 3);
        check_tetra(0, 1, 2, 4);
        set_regs(MAX_POSITIONS, 48'd16777216);
        check_tetra(0, 1, 2, 3);
        set_regs(MAX_POSITIONS, 48'd16777217);
        check_tetra(0, 1, 2, 3);

        // The result side holds off while items keep coming, so the input backs up.
        set_regs(MAX_POSITIONS, 48'd2);
        mesh_slots.delete();
        for (k = 0; k < 8; k++) begin
            put_vertex(200 + k, rand_coord(COORD_BITS), rand_coord(COORD_BITS),
                       rand_coord(COORD_BITS));
            mesh_slots.push_back(200 + k);
        end
        tx_calm = 1'b1;
        rx_calm = 1'b0;
        hold_go = 1'b1;
        for (k = 0; k < 60; k++) begin
            check_tetra(pick_slot(), pick_slot(), pick_slot(), pick_slot());
        end

        while (items_sent < ITEM_TARGET) begin
            random_phase();
        end

        settle();
        if (fail_count == 0 && pending_results == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> tetra_orientation_checker.f
sv/toc_pkg.sv
sv/toc_ram.sv
sv/tetra_orientation_checker.sv
test/tetra_result_checker.sv
test/tetra_orientation_checker_tb.sv
